// ----- sv/fcsg_pkg.sv -----
`default_nettype none
package fcsg_pkg;

   localparam int CoordBits   = 16;
   localparam int OutBits     = CoordBits + 1;
   localparam int RadBits     = 7;
   localparam int MaxRadius   = 127;
   localparam int MaxResults  = 64;
   localparam int RowsPerItem = MaxResults / 4;
   localparam int OffBits     = RadBits + 1;
   localparam int SqBits      = 2 * RadBits;
   localparam int SqrtSteps   = RadBits;
   localparam int StepBits    = $clog2(SqrtSteps);

   typedef enum logic [1:0] {
      SEG_BOTTOM = 2'd0,
      SEG_TOP    = 2'd1,
      SEG_LEFT   = 2'd2,
      SEG_RIGHT  = 2'd3
   } seg_kind_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic sqrt_step;
      logic finish;
      logic advance;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic active_next;
      logic empty_row;
      logic last_seg;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- sv/filled_circle_span_generator.sv -----
`default_nettype none
// Fills a circle with line segments, one row offset per request. A request with
// start_circle set latches centre and radius and begins at offset zero; each
// later request handles the next offset until the offset reaches the radius,
// then the circle ends and further requests without start_circle give nothing.
// Each handled request emits four segments (bottom, top, left, right) for every
// half-width from the new one up to the previous one, at most sixteen
// half-widths, with last_of_row on the final segment and circle_done on all
// segments of the last offset. A request passes through accept, setup, the
// bit-pair square root unit and finish, then one segment per cycle is taken
// at the output while rsp_ready is high. One request is in flight at a time;
// the next request is taken once the last segment has been taken.
module filled_circle_span_generator (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire                                    req_start_circle,
   input  wire signed [fcsg_pkg::CoordBits-1:0]   req_centre_x,
   input  wire signed [fcsg_pkg::CoordBits-1:0]   req_centre_y,
   input  wire        [fcsg_pkg::RadBits-1:0]     req_radius,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic signed [fcsg_pkg::OutBits-1:0]    rsp_x_start,
   output logic signed [fcsg_pkg::OutBits-1:0]    rsp_y_start,
   output logic signed [fcsg_pkg::OutBits-1:0]    rsp_x_end,
   output logic signed [fcsg_pkg::OutBits-1:0]    rsp_y_end,
   output logic                                   rsp_last_of_row,
   output logic                                   rsp_circle_done
);
   import fcsg_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   fcsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   fcsg_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_start_circle (req_start_circle),
      .req_centre_x     (req_centre_x),
      .req_centre_y     (req_centre_y),
      .req_radius       (req_radius),
      .rsp_x_start      (rsp_x_start),
      .rsp_y_start      (rsp_y_start),
      .rsp_x_end        (rsp_x_end),
      .rsp_y_end        (rsp_y_end),
      .rsp_last_of_row  (rsp_last_of_row),
      .rsp_circle_done  (rsp_circle_done)
   );

endmodule
`default_nettype wire

// ----- sv/fcsg_dpath.sv -----
`default_nettype none
module fcsg_dpath (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire fcsg_pkg::dp_cmd_type              cmd,
   output fcsg_pkg::dp_status_type                status,
   input  wire                                    req_start_circle,
   input  wire signed [fcsg_pkg::CoordBits-1:0]   req_centre_x,
   input  wire signed [fcsg_pkg::CoordBits-1:0]   req_centre_y,
   input  wire        [fcsg_pkg::RadBits-1:0]     req_radius,
   output logic signed [fcsg_pkg::OutBits-1:0]    rsp_x_start,
   output logic signed [fcsg_pkg::OutBits-1:0]    rsp_y_start,
   output logic signed [fcsg_pkg::OutBits-1:0]    rsp_x_end,
   output logic signed [fcsg_pkg::OutBits-1:0]    rsp_y_end,
   output logic                                   rsp_last_of_row,
   output logic                                   rsp_circle_done
);
   import fcsg_pkg::*;

   logic                        active_ff, active_in;
   logic [OffBits-1:0]          offset_ff, offset_in;
   logic [OffBits-1:0]          prev_ff, prev_in;
   logic signed [CoordBits-1:0] cx_ff, cx_in;
   logic signed [CoordBits-1:0] cy_ff, cy_in;
   logic [RadBits-1:0]          rad_ff, rad_in;
   logic [RadBits-1:0]          k_ff, k_in;
   logic [SqBits-1:0]           rem_ff, rem_in;
   logic [SqBits-1:0]           root_ff, root_in;
   logic [SqBits-1:0]           bit_ff, bit_in;
   logic [OffBits-1:0]          last_h_ff, last_h_in;
   logic [OffBits-1:0]          h_ff, h_in;
   seg_kind_type                seg_ff, seg_in;
   logic                        done_ff, done_in;

   logic [RadBits-1:0]          sat_rad;
   logic [RadBits-1:0]          k_sel;
   logic [SqBits:0]             trial;
   logic [OffBits-1:0]          w;
   logic [OffBits:0]            w_lim;
   logic                        done_now;

   logic signed [OutBits-1:0]   cx_ext, cy_ext, h_ext, k_ext;

   always_comb begin
      sat_rad  = (req_radius > RadBits'(MaxRadius)) ? RadBits'(MaxRadius) : req_radius;
      k_sel    = (offset_ff > OffBits'(rad_ff)) ? rad_ff : offset_ff[RadBits-1:0];
      trial    = (SqBits + 1)'(root_ff) + (SqBits + 1)'(bit_ff);
      w        = root_ff[OffBits-1:0];
      w_lim    = (OffBits + 1)'(w) + (OffBits + 1)'(RowsPerItem);
      done_now = (k_ff == rad_ff);
   end

   assign status.active_next = req_start_circle | active_ff;
   assign status.empty_row   = (w > prev_ff);
   assign status.last_seg    = (seg_ff == SEG_RIGHT) && (h_ff == last_h_ff);

   always_comb begin
      active_in = active_ff;
      offset_in = offset_ff;
      prev_in   = prev_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      rad_in    = rad_ff;
      k_in      = k_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      last_h_in = last_h_ff;
      h_in      = h_ff;
      seg_in    = seg_ff;
      done_in   = done_ff;

      if (cmd.load && req_start_circle) begin
         cx_in     = req_centre_x;
         cy_in     = req_centre_y;
         rad_in    = sat_rad;
         offset_in = '0;
         prev_in   = OffBits'(sat_rad) + OffBits'(1);
         active_in = 1'b1;
      end

      if (cmd.prep) begin
         k_in    = k_sel;
         rem_in  = SqBits'(rad_ff) * SqBits'(rad_ff) - SqBits'(k_sel) * SqBits'(k_sel);
         root_in = '0;
         bit_in  = SqBits'(1) << (2 * (SqrtSteps - 1));
      end

      if (cmd.sqrt_step) begin
         if ((SqBits + 1)'(rem_ff) >= trial) begin
            rem_in  = rem_ff - trial[SqBits-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end

      if (cmd.finish) begin
         h_in    = w;
         seg_in  = SEG_BOTTOM;
         done_in = done_now;
         if ((OffBits + 1)'(prev_ff) >= w_lim) begin
            last_h_in = w + OffBits'(RowsPerItem - 1);
         end else begin
            last_h_in = prev_ff;
         end
      end

      if (cmd.advance) begin
         if (seg_ff == SEG_RIGHT) begin
            seg_in = SEG_BOTTOM;
            h_in   = h_ff + OffBits'(1);
         end else begin
            seg_in = seg_kind_type'(seg_ff + 2'd1);
         end
      end

      if (cmd.commit) begin
         prev_in = w;
         if (done_now) begin
            active_in = 1'b0;
            offset_in = OffBits'(k_ff);
         end else begin
            offset_in = OffBits'(k_ff) + OffBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         offset_ff <= '0;
         prev_ff   <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         rad_ff    <= '0;
      end else begin
         active_ff <= active_in;
         offset_ff <= offset_in;
         prev_ff   <= prev_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         rad_ff    <= rad_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
      last_h_ff <= last_h_in;
      h_ff      <= h_in;
      seg_ff    <= seg_in;
      done_ff   <= done_in;
   end

   always_comb begin
      cx_ext = OutBits'(cx_ff);
      cy_ext = OutBits'(cy_ff);
      h_ext  = signed'(OutBits'(h_ff));
      k_ext  = signed'(OutBits'(k_ff));
      unique case (seg_ff)
         SEG_BOTTOM: begin
            rsp_x_start = cx_ext + k_ext;
            rsp_y_start = cy_ext + h_ext;
            rsp_x_end   = cx_ext - k_ext;
            rsp_y_end   = cy_ext + h_ext;
         end
         SEG_TOP: begin
            rsp_x_start = cx_ext + k_ext;
            rsp_y_start = cy_ext - h_ext;
            rsp_x_end   = cx_ext - k_ext;
            rsp_y_end   = cy_ext - h_ext;
         end
         SEG_LEFT: begin
            rsp_x_start = cx_ext - h_ext;
            rsp_y_start = cy_ext + k_ext;
            rsp_x_end   = cx_ext - h_ext;
            rsp_y_end   = cy_ext - k_ext;
         end
         SEG_RIGHT: begin
            rsp_x_start = cx_ext + h_ext;
            rsp_y_start = cy_ext + k_ext;
            rsp_x_end   = cx_ext + h_ext;
            rsp_y_end   = cy_ext - k_ext;
         end
         default: begin
            rsp_x_start = cx_ext;
            rsp_y_start = cy_ext;
            rsp_x_end   = cx_ext;
            rsp_y_end   = cy_ext;
         end
      endcase
      rsp_last_of_row = status.last_seg;
      rsp_circle_done = done_ff;
   end

endmodule
`default_nettype wire

// ----- sv/fcsg_ctrl.sv -----
`default_nettype none
module fcsg_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output fcsg_pkg::dp_cmd_type     cmd,
   input  wire fcsg_pkg::dp_status_type status
);
   import fcsg_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_SQRT = 5'b00100,
      ST_FIN  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [StepBits-1:0] step_cnt_ff, step_cnt_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.active_next) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cmd.prep    = 1'b1;
            step_cnt_in = StepBits'(SqrtSteps - 1);
            state_in    = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_cnt_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               step_cnt_in = step_cnt_ff - StepBits'(1);
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            if (status.empty_row) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (status.last_seg) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_commit_place: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (state_ff == ST_FIN) || ((state_ff == ST_EMIT) && rsp_ready))
      else $error("commit outside finish or final segment");

   a_sqrt_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) && (step_cnt_ff == '0) |=> (state_ff == ST_FIN))
      else $error("square root did not finish on last step");

   a_idle_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !status.active_next |=> (state_ff == ST_IDLE))
      else $error("idle request started work");

   a_fin_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> (state_ff == ST_IDLE) || (state_ff == ST_EMIT))
      else $error("bad exit from finish");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_filled_circle_span_generator.sv -----
module tb_filled_circle_span_generator;
   import fcsg_pkg::*;

   typedef struct {
      logic signed [OutBits-1:0] x_start;
      logic signed [OutBits-1:0] y_start;
      logic signed [OutBits-1:0] x_end;
      logic signed [OutBits-1:0] y_end;
      logic                      last_of_row;
      logic                      circle_done;
   } span_seg_type;

   class span_scoreboard;
      span_seg_type awaited_spans[$];
      int           failures;
      bit [7:0]     row_offset;
      bit [7:0]     prev_half_width;
      int           held_cx;
      int           held_cy;
      int           held_radius;
      bit           circle_active;

      function new();
         failures = 0;
         row_offset = '0;
         prev_half_width = '0;
         held_cx = 0;
         held_cy = 0;
         held_radius = 0;
         circle_active = 1'b0;
      endfunction

      function int floor_root(int n);
         int g;
         g = 0;
         while ((g + 1) * (g + 1) <= n)
            g++;
         return g;
      endfunction

      function void note_request(bit start, logic signed [CoordBits-1:0] cx,
                                 logic signed [CoordBits-1:0] cy,
                                 logic [RadBits-1:0] rad);
         int           k;
         int           w;
         int           top_h;
         int           n;
         bit           done;
         seg_kind_type kind;
         span_seg_type seg;
         if (start) begin
            held_cx = int'(cx);
            held_cy = int'(cy);
            held_radius = (int'(rad) > MaxRadius) ? MaxRadius : int'(rad);
            row_offset = '0;
            prev_half_width = 8'(held_radius + 1);
            circle_active = 1'b1;
         end
         if (!circle_active)
            return;
         k = int'(row_offset);
         if (k > held_radius)
            k = held_radius;
         w = floor_root(held_radius * held_radius - k * k);
         top_h = int'(prev_half_width);
         if (top_h >= w + RowsPerItem)
            top_h = w + RowsPerItem - 1;
         done = (k >= held_radius);
         n = 0;
         for (int h = w; h <= top_h; h++) begin
            for (int s = 0; s < 4; s++) begin
               kind = seg_kind_type'(s);
               case (kind)
                  SEG_BOTTOM: begin
                     seg.x_start = OutBits'(held_cx + k);
                     seg.y_start = OutBits'(held_cy + h);
                     seg.x_end   = OutBits'(held_cx - k);
                     seg.y_end   = OutBits'(held_cy + h);
                  end
                  SEG_TOP: begin
                     seg.x_start = OutBits'(held_cx + k);
                     seg.y_start = OutBits'(held_cy - h);
                     seg.x_end   = OutBits'(held_cx - k);
                     seg.y_end   = OutBits'(held_cy - h);
                  end
                  SEG_LEFT: begin
                     seg.x_start = OutBits'(held_cx - h);
                     seg.y_start = OutBits'(held_cy + k);
                     seg.x_end   = OutBits'(held_cx - h);
                     seg.y_end   = OutBits'(held_cy - k);
                  end
                  default: begin
                     seg.x_start = OutBits'(held_cx + h);
                     seg.y_start = OutBits'(held_cy + k);
                     seg.x_end   = OutBits'(held_cx + h);
                     seg.y_end   = OutBits'(held_cy - k);
                  end
               endcase
               seg.last_of_row = 1'b0;
               seg.circle_done = done;
               awaited_spans = {awaited_spans, seg};
               n++;
            end
         end
         if (n > 0)
            awaited_spans[awaited_spans.size() - 1].last_of_row = 1'b1;
         prev_half_width = w[7:0];
         if (done) begin
            circle_active = 1'b0;
            row_offset = k[7:0];
         end else begin
            row_offset = k[7:0] + 8'd1;
         end
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_span(span_seg_type got);
         span_seg_type want;
         if (awaited_spans.size() == 0) begin
            $error("unexpected segment (%0d,%0d)-(%0d,%0d)",
                   got.x_start, got.y_start, got.x_end, got.y_end);
            failures++;
            return;
         end
         want = awaited_spans.pop_front();
         compare_field("x_start", int'(want.x_start), int'(got.x_start));
         compare_field("y_start", int'(want.y_start), int'(got.y_start));
         compare_field("x_end", int'(want.x_end), int'(got.x_end));
         compare_field("y_end", int'(want.y_end), int'(got.y_end));
         compare_field("last_of_row", int'(want.last_of_row), int'(got.last_of_row));
         compare_field("circle_done", int'(want.circle_done), int'(got.circle_done));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_start_circle = 1'b0;
   logic signed [CoordBits-1:0]       req_centre_x = '0;
   logic signed [CoordBits-1:0]       req_centre_y = '0;
   logic        [RadBits-1:0]         req_radius = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [OutBits-1:0]         rsp_x_start;
   logic signed [OutBits-1:0]         rsp_y_start;
   logic signed [OutBits-1:0]         rsp_x_end;
   logic signed [OutBits-1:0]         rsp_y_end;
   logic                              rsp_last_of_row;
   logic                              rsp_circle_done;

   span_scoreboard sb = new();
   bit             quiet = 1'b0;
   int             sent_requests = 0;

   always #2 clock = ~clock;

   filled_circle_span_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_circle (req_start_circle),
      .req_centre_x     (req_centre_x),
      .req_centre_y     (req_centre_y),
      .req_radius       (req_radius),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_x_start      (rsp_x_start),
      .rsp_y_start      (rsp_y_start),
      .rsp_x_end        (rsp_x_end),
      .rsp_y_end        (rsp_y_end),
      .rsp_last_of_row  (rsp_last_of_row),
      .rsp_circle_done  (rsp_circle_done)
   );

   always @(posedge clock) begin
      span_seg_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.x_start = rsp_x_start;
         got.y_start = rsp_y_start;
         got.x_end = rsp_x_end;
         got.y_end = rsp_y_end;
         got.last_of_row = rsp_last_of_row;
         got.circle_done = rsp_circle_done;
         sb.check_span(got);
      end
   end

   // stall the result side in bursts
   initial begin
      wait (reset == 1'b0);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   function automatic logic signed [CoordBits-1:0] pick_coord();
      if ($urandom_range(0, 5) != 0)
         return CoordBits'($urandom);
      case ($urandom_range(0, 3))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   task automatic send_request(input bit start, input logic signed [CoordBits-1:0] cx,
                               input logic signed [CoordBits-1:0] cy,
                               input logic [RadBits-1:0] rad);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_circle <= start;
      req_centre_x <= cx;
      req_centre_y <= cy;
      req_radius <= rad;
      do @(posedge clock); while (!req_ready);
      sb.note_request(start, cx, cy, rad);
      sent_requests++;
   endtask

   task automatic drain(input int settle);
      req_valid <= 1'b0;
      while (sb.awaited_spans.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      #8000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [RadBits-1:0]          rad;
      logic signed [CoordBits-1:0] cx;
      logic signed [CoordBits-1:0] cy;
      int                          rows;
      int                          target;
      bit                          first_big;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(1'b0, 16'sh1234, -16'sh1234, 7'd5);
      send_request(1'b1, 16'sd0, 16'sd0, 7'd0);
      send_request(1'b0, -16'sd1, -16'sd1, 7'd127);
      send_request(1'b1, -16'sd1, 16'sd1, 7'd1);
      send_request(1'b0, 16'sd0, 16'sd0, 7'd0);
      send_request(1'b1, 16'sh7FFF, 16'sh8000, 7'd127);
      repeat (3)
         send_request(1'b0, CoordBits'($urandom), CoordBits'($urandom), RadBits'($urandom));
      drain(30);
      send_request(1'b1, 16'sh8000, 16'sh7FFF, 7'd127);
      repeat (2)
         send_request(1'b0, CoordBits'($urandom), CoordBits'($urandom), RadBits'($urandom));
      send_request(1'b1, 16'sh5555, 16'shAAAA, 7'd2);
      repeat (2) send_request(1'b0, 16'shAAAA, 16'sh5555, 7'd85);
      send_request(1'b1, 16'shAAAA, 16'sh5555, 7'd85);
      send_request(1'b1, 16'sd100, -16'sd100, 7'd3);
      repeat (3) send_request(1'b0, 16'sd0, 16'sd0, 7'd0);
      send_request(1'b0, 16'sd7, 16'sd7, 7'd7);

      target = sent_requests + 410;
      first_big = 1'b1;
      while (sent_requests < target) begin
         if (sent_requests >= target - 70)
            quiet = 1'b1;
         if (!quiet && $urandom_range(0, 11) == 0)
            drain(20);
         if ($urandom_range(0, 9) == 0) begin
            send_request(1'b0, CoordBits'($urandom), CoordBits'($urandom),
                         RadBits'($urandom));
         end else begin
            if (first_big)
               rad = 7'd127;
            else if ($urandom_range(0, 7) == 0)
               rad = RadBits'($urandom_range(0, 127));
            else
               rad = RadBits'($urandom_range(0, 15));
            first_big = 1'b0;
            cx = pick_coord();
            cy = pick_coord();
            rows = int'(rad) + 1;
            if ($urandom_range(0, 5) == 0)
               rows = int'($urandom_range(1, int'(rad) + 1));
            if (rows > target - sent_requests)
               rows = target - sent_requests;
            send_request(1'b1, cx, cy, rad);
            repeat (rows - 1)
               send_request(1'b0, CoordBits'($urandom), CoordBits'($urandom),
                            RadBits'($urandom));
         end
      end

      drain(40);
      if (sb.awaited_spans.size() != 0) begin
         $error("%0d segments never arrived", sb.awaited_spans.size());
         sb.failures++;
      end
      if (sb.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
